### src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is asserted.
`define DAD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("date_add_days check failed");

// Concurrent check on the rising clock edge that also holds during reset.
`define DAD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("date_add_days reset check failed");

`endif

### src/dad_pkg.sv
// Types, constants and calendar helpers shared by the date_add_days modules.
`timescale 1ns / 1ps
package dad_pkg;

  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int YearW    = 14;
  localparam int CountW   = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 14;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMinYear = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxYear = 1'd1;

  localparam logic [YearW-1:0] MinYearRst = 14'd1800;
  localparam logic [YearW-1:0] MaxYearRst = 14'd10000;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   FebLeap  = 5'd29;
  localparam logic [DayW-1:0]   FirstDay = 5'd1;

  // Month lengths by month number; codes outside 1..12 give zero.
  localparam logic [DayW-1:0] MonthLen [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // Multiplicative inverse of 25 modulo 2^14 and the largest product that
  // marks an exact multiple of 25.
  localparam logic [YearW-1:0] Inv25    = 14'd7209;
  localparam logic [YearW-1:0] Div25Lim = 14'd655;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic [CountW-1:0] count;
    logic              err;
    logic              leap;
  } item_t;

  typedef enum logic [0:0] {FrIdle, FrCheck} fr_state_t;
  typedef enum logic [1:0] {BkIdle, BkPrep, BkStep} bk_state_t;

  // A year is a multiple of 100 exactly when it is a multiple of 4 and of 25,
  // and a multiple of 400 when it is a multiple of 16 and of 25.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = YearW'(y * Inv25);
    div25 = (prod <= Div25Lim);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    return ((m == MonthFeb) && leap) ? FebLeap : MonthLen[m];
  endfunction

endpackage

### src/dad_front.sv
// Front end: takes input dates, holds the year range and validates each date.
`timescale 1ns / 1ps
module dad_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dad_pkg::MonthW-1:0]    in_month,
  input  logic [dad_pkg::DayW-1:0]      in_day,
  input  logic [dad_pkg::YearW-1:0]     in_year,
  input  logic [dad_pkg::CountW-1:0]    in_day_count,
  input  logic                          cfg_we,
  input  logic [dad_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dad_pkg::CfgDataW-1:0]  cfg_wdata,
  output logic                          push,
  output dad_pkg::item_t                push_item,
  input  logic                          q_full
);
  import dad_pkg::*;

  fr_state_t         state_r, state_nxt;
  logic [MonthW-1:0] month_r;
  logic [DayW-1:0]   day_r;
  logic [YearW-1:0]  year_r;
  logic [CountW-1:0] count_r;
  logic [YearW-1:0]  min_year_r;
  logic [YearW-1:0]  max_year_r;
  logic              leap;
  logic [DayW-1:0]   len;
  logic              date_ok;

  assign leap    = is_leap(year_r);
  assign len     = month_days(month_r, leap);
  // A zero length means the month code is out of range.
  assign date_ok = (year_r >= min_year_r) && (year_r <= max_year_r) &&
                   (len != '0) && (day_r != '0) && (day_r <= len);

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    case (state_r)
      FrIdle: begin
        if (start) begin
          state_nxt = FrCheck;
        end
      end
      FrCheck: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = FrIdle;
        end
      end
      default: begin
        state_nxt = FrIdle;
      end
    endcase
  end

  assign busy      = (state_r != FrIdle);
  assign push_item = {month_r, day_r, year_r, count_r, !date_ok, leap};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FrIdle;
      min_year_r <= MinYearRst;
      max_year_r <= MaxYearRst;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CfgMinYear: min_year_r <= cfg_wdata[YearW-1:0];
          CfgMaxYear: max_year_r <= cfg_wdata[YearW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == FrIdle)) begin
      month_r <= in_month;
      day_r   <= in_day;
      year_r  <= in_year;
      count_r <= in_day_count;
    end
  end

endmodule

### src/dad_queue.sv
// Short queue of checked items between the front end and the stepper.
`timescale 1ns / 1ps
module dad_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dad_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output dad_pkg::item_t pop_item,
  output logic           empty
);
  import dad_pkg::*;

  item_t            mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPtrW+1)'(QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/dad_back.sv
// Back end: advances a valid date one month per cycle and registers the result.
`timescale 1ns / 1ps
module dad_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        empty,
  input  dad_pkg::item_t              pop_item,
  output logic                        pop,
  output logic                        out_valid,
  output logic [dad_pkg::MonthW-1:0]  out_month,
  output logic [dad_pkg::DayW-1:0]    out_day,
  output logic [dad_pkg::YearW-1:0]   out_year,
  output logic                        out_date_error
);
  import dad_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [MonthW-1:0] month_r, month_nxt;
  logic [DayW-1:0]   day_r, day_nxt;
  logic [YearW-1:0]  year_r, year_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              leap_r, leap_nxt;
  logic              next_leap_r;
  logic              out_valid_r, out_valid_nxt;
  logic [MonthW-1:0] out_month_r, out_month_nxt;
  logic [DayW-1:0]   out_day_r, out_day_nxt;
  logic [YearW-1:0]  out_year_r, out_year_nxt;
  logic              out_err_r, out_err_nxt;
  logic [DayW-1:0]   len;
  logic [DayW-1:0]   left;
  logic              roll;

  assign len  = month_days(month_r, leap_r);
  assign left = len - day_r;
  assign roll = (count_r > CountW'(left));

  always_comb begin
    state_nxt     = state_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    year_nxt      = year_r;
    count_nxt     = count_r;
    leap_nxt      = leap_r;
    out_valid_nxt = 1'b0;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_year_nxt  = out_year_r;
    out_err_nxt   = out_err_r;
    pop           = 1'b0;
    case (state_r)
      BkIdle: begin
        if (!empty) begin
          pop       = 1'b1;
          month_nxt = pop_item.month;
          day_nxt   = pop_item.day;
          year_nxt  = pop_item.year;
          count_nxt = pop_item.count;
          leap_nxt  = pop_item.leap;
          if (pop_item.err) begin
            out_valid_nxt = 1'b1;
            out_month_nxt = pop_item.month;
            out_day_nxt   = pop_item.day;
            out_year_nxt  = pop_item.year;
            out_err_nxt   = 1'b1;
          end else begin
            state_nxt = BkPrep;
          end
        end
      end
      BkPrep: begin
        // Wait state so that the next-year leap flag can follow the loaded year.
        state_nxt = BkStep;
      end
      BkStep: begin
        if (roll) begin
          count_nxt = count_r - (CountW'(left) + CountW'(1));
          day_nxt   = FirstDay;
          if (month_r == MonthDec) begin
            month_nxt = MonthJan;
            year_nxt  = year_r + 1'b1;
            leap_nxt  = next_leap_r;
          end else begin
            month_nxt = month_r + 1'b1;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_month_nxt = month_r;
          out_day_nxt   = DayW'(day_r + count_r[DayW-1:0]);
          out_year_nxt  = year_r;
          out_err_nxt   = 1'b0;
          state_nxt     = BkIdle;
        end
      end
      default: begin
        state_nxt = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BkIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    month_r     <= month_nxt;
    day_r       <= day_nxt;
    year_r      <= year_nxt;
    count_r     <= count_nxt;
    leap_r      <= leap_nxt;
    // Leap flag of the following year, ready for a December rollover.
    next_leap_r <= is_leap(year_r + 1'b1);
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_year_r  <= out_year_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_month      = out_month_r;
  assign out_day        = out_day_r;
  assign out_year       = out_year_r;
  assign out_date_error = out_err_r;

endmodule

### src/date_add_days.sv
// Top level of the Gregorian date advance block.
//
//   Channel  Handshake               Payload
//   input    start / busy            in_month, in_day, in_year, in_day_count
//   result   out_valid (one cycle)   out_month, out_day, out_year, out_date_error
//   config   cfg_we                  cfg_index, cfg_wdata
//
// The front end takes no new item until it has pushed the last one into the
// two-entry queue, and it waits while the queue is full. The stepper reports an
// invalid date from idle; a valid one passes a preparation state, then a stepping
// state that crosses one month boundary at a time (at most about 2160).
// Synchronous active-low reset restores the year range to 1800..10000.
// The receiver takes every result in the cycle that out_valid marks.
`timescale 1ns / 1ps
module date_add_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dad_pkg::MonthW-1:0]    in_month,
  input  logic [dad_pkg::DayW-1:0]      in_day,
  input  logic [dad_pkg::YearW-1:0]     in_year,
  input  logic [dad_pkg::CountW-1:0]    in_day_count,
  input  logic                          cfg_we,
  input  logic [dad_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dad_pkg::CfgDataW-1:0]  cfg_wdata,
  output logic                          out_valid,
  output logic [dad_pkg::MonthW-1:0]    out_month,
  output logic [dad_pkg::DayW-1:0]      out_day,
  output logic [dad_pkg::YearW-1:0]     out_year,
  output logic                          out_date_error
);
  import dad_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  dad_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_month     (in_month),
    .in_day       (in_day),
    .in_year      (in_year),
    .in_day_count (in_day_count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  dad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  dad_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (q_empty),
    .pop_item       (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_year       (out_year),
    .out_date_error (out_date_error)
  );

endmodule

### src/dad_checker.sv
// Port-level checks for date_add_days and the bind that attaches them.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dad_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [dad_pkg::MonthW-1:0]  out_month,
  input logic [dad_pkg::DayW-1:0]    out_day,
  input logic                        out_date_error
);
  import dad_pkg::*;

  // Reset leaves the block idle with no result on the ports.
  `DAD_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_valid && !busy))

  // An accepted item keeps the front end occupied for its check state.
  `DAD_ASSERT(a_accept_busy, (start && !busy) |=> busy)

  // A transfer without the error flag carries a nonzero day and a month from January to December.
  `DAD_ASSERT(a_result_date,
    (out_valid && !out_date_error) |->
      ((out_day != '0) && (out_month >= MonthJan) && (out_month <= MonthDec)))

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_month      (out_month),
  .out_day        (out_day),
  .out_date_error (out_date_error)
);

### tb/sv/date_advance_checker.sv
// Checker for date_add_days: predicts each advanced date and compares the results.
`timescale 1ns / 1ps
module date_advance_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [dad_pkg::MonthW-1:0]   in_month,
  input  logic [dad_pkg::DayW-1:0]     in_day,
  input  logic [dad_pkg::YearW-1:0]    in_year,
  input  logic [dad_pkg::CountW-1:0]   in_day_count,
  input  logic                         cfg_we,
  input  logic [dad_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dad_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                         out_valid,
  input  logic [dad_pkg::MonthW-1:0]   out_month,
  input  logic [dad_pkg::DayW-1:0]     out_day,
  input  logic [dad_pkg::YearW-1:0]    out_year,
  input  logic                         out_date_error,
  output int                           fail_count,
  output int                           pending_count,
  output int                           checked_count,
  output int                           invalid_count
);
  import dad_pkg::*;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic              date_error;
  } date_result_t;

  localparam int DaysPerMonth [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  date_result_t     expected_dates [$];
  logic [YearW-1:0] lo_year;
  logic [YearW-1:0] hi_year;

  function automatic bit leap_year(input logic [YearW-1:0] y);
    int yi;
    yi = y;
    return (yi % 400 == 0) || ((yi % 4 == 0) && (yi % 100 != 0));
  endfunction

  function automatic int month_length(input int m, input logic [YearW-1:0] y);
    if (m < MonthJan || m > MonthDec) return 0;
    if (m == MonthFeb && leap_year(y)) return FebLeap;
    return DaysPerMonth[m];
  endfunction

  function automatic date_result_t advance_date(input logic [MonthW-1:0] m,
                                                input logic [DayW-1:0]   d,
                                                input logic [YearW-1:0]  y,
                                                input logic [CountW-1:0] n);
    date_result_t     r;
    int               cm;
    int               cd;
    int               rem;
    int               left;
    logic [YearW-1:0] cy;
    r.month      = m;
    r.day        = d;
    r.year       = y;
    r.date_error = 1'b0;
    if (y < lo_year || y > hi_year || m < MonthJan || m > MonthDec || d < FirstDay ||
        d > month_length(m, y)) begin
      r.date_error = 1'b1;
      return r;
    end
    cm  = m;
    cd  = d;
    cy  = y;
    rem = n;
    // Walk forward a month at a time; the year register wraps at its width.
    while (rem > 0) begin
      left = month_length(cm, cy) - cd;
      if (rem > left) begin
        rem = rem - (left + 1);
        cd  = FirstDay;
        if (cm == MonthDec) begin
          cm = MonthJan;
          cy = cy + 1'b1;
        end else begin
          cm = cm + 1;
        end
      end else begin
        cd  = cd + rem;
        rem = 0;
      end
    end
    r.month = MonthW'(cm);
    r.day   = DayW'(cd);
    r.year  = cy;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    date_result_t want;
    date_result_t got;
    if (!rst_n) begin
      lo_year = MinYearRst;
      hi_year = MaxYearRst;
      expected_dates.delete();
      pending_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgMinYear: lo_year = cfg_wdata;
          CfgMaxYear: hi_year = cfg_wdata;
          default: ;
        endcase
      end
      // Compare before queuing, since a result can never belong to an item
      // accepted on the same edge.
      if (out_valid) begin
        got = {out_month, out_day, out_year, out_date_error};
        if (expected_dates.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %0d/%0d/%0d err=%0d", $time,
                   got.month, got.day, got.year, got.date_error);
        end else begin
          want = expected_dates.pop_front();
          pending_count = expected_dates.size();
          checked_count++;
          if (want.month !== got.month || want.day !== got.day ||
              want.year !== got.year || want.date_error !== got.date_error) begin
            fail_count++;
            $display("%0t: date mismatch: expected %0d/%0d/%0d err=%0d, %s",
                     $time, want.month, want.day, want.year, want.date_error,
                     $sformatf("got %0d/%0d/%0d err=%0d",
                               got.month, got.day, got.year, got.date_error));
          end
        end
      end
      if (start && !busy) begin
        want = advance_date(in_month, in_day, in_year, in_day_count);
        if (want.date_error) invalid_count++;
        expected_dates.push_back(want);
        pending_count = expected_dates.size();
      end
    end
  end

endmodule

### tb/sv/date_add_days_test.sv
// Top of the date_add_days testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module date_add_days_test;
  import dad_pkg::*;

  localparam int SettleCycles = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MonthW-1:0]   in_month;
  logic [DayW-1:0]     in_day;
  logic [YearW-1:0]    in_year;
  logic [CountW-1:0]   in_day_count;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                out_valid;
  logic [MonthW-1:0]   out_month;
  logic [DayW-1:0]     out_day;
  logic [YearW-1:0]    out_year;
  logic                out_date_error;

  int fail_count;
  int pending_count;
  int checked_count;
  int invalid_count;
  int items_sent;
  int ranges_used;

  logic [YearW-1:0] lo_year;
  logic [YearW-1:0] hi_year;

  date_add_days u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_year        (in_year),
    .in_day_count   (in_day_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_year       (out_year),
    .out_date_error (out_date_error)
  );

  date_advance_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_year        (in_year),
    .in_day_count   (in_day_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_year       (out_year),
    .out_date_error (out_date_error),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .invalid_count  (invalid_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one date at a falling edge and holds it until the transfer; start
  // stays high afterward unless a gap follows.
  task automatic send_date(input logic [MonthW-1:0] m, input logic [DayW-1:0] d,
                           input logic [YearW-1:0] y, input logic [CountW-1:0] n,
                           input int gap);
    in_month     <= m;
    in_day       <= d;
    in_year      <= y;
    in_day_count <= n;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    wait (pending_count == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_year_range(input logic [YearW-1:0] lo, input logic [YearW-1:0] hi);
    lo_year   = lo;
    hi_year   = hi;
    cfg_we    <= 1'b1;
    cfg_index <= CfgMinYear;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CfgMaxYear;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ranges_used++;
  endtask

  task automatic send_random_date(input int gap);
    logic [MonthW-1:0] m;
    logic [DayW-1:0]   d;
    logic [YearW-1:0]  y;
    logic [CountW-1:0] n;
    int                kind;
    int                pick;
    int                span;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    m = MonthW'($urandom_range(MonthJan, MonthDec));
    d = ($urandom_range(0, 9) < 7) ? DayW'($urandom_range(1, 28)) :
                                     DayW'($urandom_range(29, 31));
    y = (pick == 0) ? lo_year : (pick == 1) ? hi_year :
                                YearW'($urandom_range(hi_year, lo_year));
    // Mostly short counts keep the month stepper quick; a few use the full width.
    span = $urandom_range(0, 99);
    if (span < 50)      n = CountW'($urandom_range(0, 60));
    else if (span < 80) n = CountW'($urandom_range(0, 1500));
    else if (span < 93) n = CountW'($urandom_range(0, 20000));
    else                n = CountW'($urandom);
    if (kind >= 85) begin
      {m, d, y} = (MonthW+DayW+YearW)'($urandom);
      n = CountW'($urandom);
    end else if (kind >= 70) begin
      case ($urandom_range(0, 3))
        0: y = lo_year - 1'b1;
        1: y = hi_year + 1'b1;
        2: m = (pick < 5) ? 4'd0 : MonthW'($urandom_range(13, 15));
        default: d = 5'd0;
      endcase
    end
    send_date(m, d, y, n, gap);
  endtask

  task automatic run_random(input int count);
    int burst_left;
    int gap;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 20);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, 16);
      end
      if ($urandom_range(0, 49) == 0) drain_results();
      send_random_date(gap);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_month     = '0;
    in_day       = '0;
    in_year      = '0;
    in_day_count = '0;
    cfg_we       = 1'b0;
    cfg_index    = CfgMinYear;
    cfg_wdata    = '0;
    items_sent   = 0;
    ranges_used  = 0;
    lo_year      = MinYearRst;
    hi_year      = MaxYearRst;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed dates under the reset year range.
    send_date(4'd2,  5'd29, 14'd2000,  16'd0,     0);
    send_date(4'd2,  5'd29, 14'd1900,  16'd5,     0);
    send_date(4'd2,  5'd29, 14'd2004,  16'd1,     2);
    send_date(4'd2,  5'd28, 14'd2001,  16'd1,     0);
    send_date(4'd12, 5'd31, 14'd1999,  16'd1,     5);
    send_date(4'd0,  5'd10, 14'd2000,  16'd3,     0);
    send_date(4'd13, 5'd10, 14'd2000,  16'd3,     0);
    send_date(4'd15, 5'd31, 14'd16383, 16'd65535, 1);
    send_date(4'd3,  5'd0,  14'd2000,  16'd3,     0);
    send_date(4'd4,  5'd31, 14'd2000,  16'd3,     0);
    send_date(4'd1,  5'd31, 14'd2000,  16'd0,     0);
    send_date(4'd6,  5'd15, 14'd1799,  16'd7,     3);
    send_date(4'd1,  5'd1,  14'd1800,  16'd65535, 0);
    send_date(4'd12, 5'd31, 14'd10000, 16'd65535, 0);
    send_date(4'd6,  5'd15, 14'd10001, 16'd7,     16);
    send_date(4'd1,  5'd1,  14'd0,     16'd1,     0);
    send_date(4'd2,  5'd29, 14'd2400,  16'd365,   0);
    send_date(4'd2,  5'd28, 14'd2100,  16'd1,     4);
    send_date(4'd11, 5'd30, 14'd2023,  16'd31,    0);
    send_date(4'd1,  5'd31, 14'd2024,  16'd29,    0);
    drain_results();

    set_year_range(14'd0, 14'd16200);
    send_date(4'd1,  5'd1,  14'd0,     16'd0,     0);
    send_date(4'd12, 5'd31, 14'd16200, 16'd65535, 0);
    run_random(45);
    drain_results();

    set_year_range(14'd2000, 14'd2000);
    run_random(30);
    drain_results();

    // An empty year range turns every date into an error.
    set_year_range(14'd5000, 14'd100);
    run_random(20);
    drain_results();

    set_year_range(14'd16200, 14'd16200);
    run_random(25);
    drain_results();

    set_year_range(YearW'($urandom_range(0, 8000)), YearW'($urandom_range(8000, 16200)));
    run_random(55);
    drain_results();

    set_year_range(MinYearRst, MaxYearRst);
    run_random(75);
    drain_results();

    $display("Sent %0d dates over %0d year ranges; %0d results checked, %0d invalid dates.",
             items_sent, ranges_used + 1, checked_count, invalid_count);
    if (fail_count == 0) begin
      $display("date_add_days_test: clean");
    end else begin
      $display("date_add_days_test: errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding.", pending_count);
    $display("date_add_days_test: errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/dad_pkg.sv
src/dad_front.sv
src/dad_queue.sv
src/dad_back.sv
src/date_add_days.sv
src/dad_checker.sv
tb/sv/date_advance_checker.sv
tb/sv/date_add_days_test.sv
